FILE: rtl/polyphonic_dds_mixer_unit_defines.svh
// ---------------------------------------------------------------------------
// polyphonic dds mixer unit assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef POLYPHONIC_DDS_MIXER_UNIT_DEFINES_SVH
`define POLYPHONIC_DDS_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDM_ASSERT_IMP(lbl, ante, cons, msg)
`define PDM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/pdm_pkg.sv
// ---------------------------------------------------------------------------
// pdm_pkg
// constants, register codes and the sine table of the polyphonic dds mixer
// ---------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  localparam int unsigned VOICES      = 2;
  localparam int unsigned ROM_DEPTH   = 256;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned IDX_W       = $clog2(ROM_DEPTH);
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned SUM_W       = SAMPLE_W + 1;
  localparam int unsigned DAC_W       = 14;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned KEYS_W      = 2;
  localparam int unsigned NUM_CFG     = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // product of mix and gain, plus the bias that makes it nonnegative
  localparam int unsigned PROD_W    = 22;
  localparam int unsigned DAC_SHIFT = 9;
  localparam int unsigned DAC_LSB_W = 12;

  localparam logic [DAC_W-1:0]       DAC_CHAN_A = 14'h3000;
  localparam logic signed [PROD_W-1:0] MIX_GAIN = 22'sd511;
  localparam logic signed [PROD_W-1:0] DAC_BIAS = 22'sd2048 <<< DAC_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP_V0 = 1'b0,
    CFG_PHASE_STEP_V1 = 1'b1
  } cfg_reg_e;

  localparam logic [PHASE_W-1:0] STEP_RST [NUM_CFG] = '{32'd64179082, 32'd96207267};

  // entry i = trunc(2047 * sin(i * 6.283 / 256))
  localparam logic signed [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    12'sd0, 12'sd50, 12'sd100, 12'sd150, 12'sd200, 12'sd250, 12'sd300, 12'sd349,
    12'sd399, 12'sd448, 12'sd497, 12'sd545, 12'sd594, 12'sd642, 12'sd689, 12'sd736,
    12'sd783, 12'sd829, 12'sd875, 12'sd920, 12'sd964, 12'sd1008, 12'sd1052, 12'sd1095,
    12'sd1137, 12'sd1178, 12'sd1219, 12'sd1259, 12'sd1298, 12'sd1337, 12'sd1374, 12'sd1411,
    12'sd1447, 12'sd1482, 12'sd1516, 12'sd1549, 12'sd1582, 12'sd1613, 12'sd1644, 12'sd1673,
    12'sd1701, 12'sd1729, 12'sd1755, 12'sd1781, 12'sd1805, 12'sd1828, 12'sd1850, 12'sd1871,
    12'sd1891, 12'sd1909, 12'sd1927, 12'sd1943, 12'sd1958, 12'sd1972, 12'sd1985, 12'sd1997,
    12'sd2007, 12'sd2016, 12'sd2024, 12'sd2031, 12'sd2037, 12'sd2041, 12'sd2044, 12'sd2046,
    12'sd2046, 12'sd2046, 12'sd2044, 12'sd2041, 12'sd2037, 12'sd2031, 12'sd2024, 12'sd2016,
    12'sd2007, 12'sd1997, 12'sd1985, 12'sd1972, 12'sd1958, 12'sd1943, 12'sd1927, 12'sd1909,
    12'sd1891, 12'sd1871, 12'sd1850, 12'sd1828, 12'sd1805, 12'sd1781, 12'sd1755, 12'sd1729,
    12'sd1702, 12'sd1673, 12'sd1644, 12'sd1613, 12'sd1582, 12'sd1550, 12'sd1516, 12'sd1482,
    12'sd1447, 12'sd1411, 12'sd1374, 12'sd1337, 12'sd1298, 12'sd1259, 12'sd1219, 12'sd1178,
    12'sd1137, 12'sd1095, 12'sd1052, 12'sd1009, 12'sd965, 12'sd920, 12'sd875, 12'sd829,
    12'sd783, 12'sd736, 12'sd689, 12'sd642, 12'sd594, 12'sd546, 12'sd497, 12'sd448,
    12'sd399, 12'sd350, 12'sd300, 12'sd250, 12'sd200, 12'sd150, 12'sd100, 12'sd50,
    12'sd0, -12'sd50, -12'sd100, -12'sd150, -12'sd200, -12'sd250, -12'sd300, -12'sd349,
    -12'sd399, -12'sd448, -12'sd497, -12'sd545, -12'sd594, -12'sd641, -12'sd689, -12'sd736,
    -12'sd783, -12'sd829, -12'sd875, -12'sd920, -12'sd964, -12'sd1008, -12'sd1052, -12'sd1094,
    -12'sd1137, -12'sd1178, -12'sd1219, -12'sd1259, -12'sd1298, -12'sd1336, -12'sd1374,
    -12'sd1411,
    -12'sd1447, -12'sd1482, -12'sd1516, -12'sd1549, -12'sd1582, -12'sd1613, -12'sd1644,
    -12'sd1673,
    -12'sd1701, -12'sd1729, -12'sd1755, -12'sd1780, -12'sd1805, -12'sd1828, -12'sd1850,
    -12'sd1871,
    -12'sd1891, -12'sd1909, -12'sd1927, -12'sd1943, -12'sd1958, -12'sd1972, -12'sd1985,
    -12'sd1997,
    -12'sd2007, -12'sd2016, -12'sd2024, -12'sd2031, -12'sd2037, -12'sd2041, -12'sd2044,
    -12'sd2046,
    -12'sd2046, -12'sd2046, -12'sd2044, -12'sd2041, -12'sd2037, -12'sd2031, -12'sd2024,
    -12'sd2016,
    -12'sd2007, -12'sd1997, -12'sd1985, -12'sd1972, -12'sd1958, -12'sd1943, -12'sd1927,
    -12'sd1909,
    -12'sd1891, -12'sd1871, -12'sd1850, -12'sd1828, -12'sd1805, -12'sd1781, -12'sd1755,
    -12'sd1729,
    -12'sd1702, -12'sd1673, -12'sd1644, -12'sd1613, -12'sd1582, -12'sd1550, -12'sd1516,
    -12'sd1482,
    -12'sd1447, -12'sd1411, -12'sd1374, -12'sd1337, -12'sd1298, -12'sd1259, -12'sd1219,
    -12'sd1178,
    -12'sd1137, -12'sd1095, -12'sd1052, -12'sd1009, -12'sd965, -12'sd920, -12'sd875,
    -12'sd829,
    -12'sd783, -12'sd737, -12'sd689, -12'sd642, -12'sd594, -12'sd546, -12'sd497, -12'sd448,
    -12'sd399, -12'sd350, -12'sd300, -12'sd250, -12'sd201, -12'sd150, -12'sd100, -12'sd50
  };

endpackage

`default_nettype wire

FILE: rtl/polyphonic_dds_mixer_unit.sv
// ---------------------------------------------------------------------------
// polyphonic dds mixer unit
// two-voice phase-accumulator sine synthesizer with averaging mixer and
// dac command formatter
// ---------------------------------------------------------------------------
// usage:
//   each item on the slave stream is one sample tick carrying the held-key
//   mask; each accepted item yields exactly one item on the master stream
//   with the averaged sample, the 14-bit dac command and the
//   number of held voices
//   phase steps are written through the cfg port while the block is idle
// timing:
//   two register stages; an accepted item passes the tick stage, then the
//   output register, where its result turns valid; one item per cycle is
//   sustained as long as the sink keeps m_axis_tready high (throughput set by
//   the phase adder and the table lookup/mix path, each one stage)
// reset:
//   phase accumulators clear to zero, phase steps take their default
//   values, both stages empty
// stall:
//   a stalled result holds in the output register; the tick stage behind it
//   still fills, then s_axis_tready drops until the sink takes the result
// ---------------------------------------------------------------------------
`default_nettype none

`include "polyphonic_dds_mixer_unit_defines.svh"

module polyphonic_dds_mixer_unit
  import pdm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [PHASE_W-1:0]     cfg_data_i,
  // tick stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] keys_held, rest zero
  // sample stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata    // [11:0] mix_sample,
                                                      // [25:12] dac_word,
                                                      // [27:26] voices_active
);

  // config registers
  logic [PHASE_W-1:0] step_q [NUM_CFG];

  // per-voice phase, packed so it can be compared as a whole
  logic [VOICES-1:0][PHASE_W-1:0] phase_q;
  logic [VOICES-1:0][PHASE_W-1:0] phase_d;

  // tick stage: held mask and table addresses
  logic                  s1_vld_q;
  logic [VOICES-1:0]     s1_keys_q;
  logic [IDX_W-1:0]      s1_idx_q [VOICES];
  logic [IDX_W-1:0]      s1_idx_d [VOICES];

  // output stage
  logic                        out_vld_q;
  logic signed [SAMPLE_W-1:0]  mix_q, mix_d;
  logic [DAC_W-1:0]            dac_q, dac_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  logic in_acc;
  logic s1_adv;

  logic [KEYS_W-1:0]         keys_in;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_adj;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         biased;

  // ---------------------------------------------------------------------
  // handshake: output register frees when empty or taken, tick stage
  // frees when it can move forward
  // ---------------------------------------------------------------------
  assign s1_adv        = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign keys_in       = s_axis_tdata[KEYS_W-1:0];

  // ---------------------------------------------------------------------
  // config writes; an index beyond the list is ignored
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < NUM_CFG; r++) begin
        step_q[r] <= STEP_RST[r];
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PHASE_STEP_V0: step_q[0] <= cfg_data_i;
        CFG_PHASE_STEP_V1: step_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // phase advance: held voices step, released voices keep their phase;
  // the table address is the top byte of the advanced phase
  // ---------------------------------------------------------------------
  always_comb begin
    for (int unsigned v = 0; v < VOICES; v++) begin
      phase_d[v]  = phase_q[v] + step_q[v];
      s1_idx_d[v] = phase_d[v][PHASE_W-1 -: IDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_acc) begin
      for (int unsigned v = 0; v < VOICES; v++) begin
        if (keys_in[v]) begin
          phase_q[v] <= phase_d[v];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_keys_q <= keys_in[VOICES-1:0];
      s1_idx_q  <= s1_idx_d;
    end
  end

  // ---------------------------------------------------------------------
  // table lookup, sum and average; with two voices the halving rounds
  // toward zero by adding the sign bit before the shift
  // ---------------------------------------------------------------------
  always_comb begin
    sum   = '0;
    cnt_d = '0;
    for (int unsigned v = 0; v < VOICES; v++) begin
      if (s1_keys_q[v]) begin
        sum   = sum + SUM_W'(SINE_ROM[s1_idx_q[v]]);
        cnt_d = cnt_d + CNT_W'(1);
      end
    end
    sum_adj = sum + SUM_W'(sum[SUM_W-1]);
    case (cnt_d)
      CNT_W'(0): mix_d = '0;
      CNT_W'(1): mix_d = sum[SAMPLE_W-1:0];
      default:   mix_d = sum_adj[SUM_W-1:1];
    endcase
  end

  // dac command: floor(511 * mix / 512) + 2048 in the low 12 bits
  always_comb begin
    prod   = PROD_W'(mix_d) * MIX_GAIN;
    biased = prod + DAC_BIAS;
    dac_d  = DAC_CHAN_A | DAC_W'(biased[DAC_SHIFT +: DAC_LSB_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      mix_q <= mix_d;
      dac_q <= dac_d;
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, cnt_q, dac_q, mix_q};

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `PDM_ASSERT_IMP(a_silent_tick, out_vld_q && (cnt_q == '0), (mix_q == '0) && (dac_q == (DAC_CHAN_A | DAC_W'(1 << (DAC_LSB_W - 1)))), "silent tick with nonzero output")
  `PDM_ASSERT_IMP(a_cnt_range, out_vld_q, cnt_q <= CNT_W'(VOICES), "voice count above voice total")
  `PDM_ASSERT_NXT(a_phase_hold, !in_acc, $stable(phase_q), "phase moved without a tick")
  `PDM_ASSERT_NXT(a_stage_hold, s1_vld_q && !s1_adv, s1_vld_q, "tick stage lost an item")

endmodule

`default_nettype wire
